### rtl/fvc_pkg.sv
// Shared constants, types and the arctangent table for the free-look camera block.
`default_nettype none
package fvc_pkg;

    // item kinds carried on tuser
    localparam logic [1:0] KIND_LOOK = 2'd0;
    localparam logic [1:0] KIND_ZOOM = 2'd1;
    localparam logic [1:0] KIND_POSE = 2'd2;

    // configuration register indexes
    localparam logic CFG_SENS = 1'b0;
    localparam logic CFG_ZOOM = 1'b1;

    localparam int NUM_W = 47;   // divider dividend width
    localparam int QUO_W = 15;   // divider quotient width

    typedef logic signed [32:0] trig_t;   // Q1.30 with headroom
    typedef logic signed [15:0] unit_t;   // Q2.14
    typedef logic signed [26:0] ang_t;    // Q.16 degrees

    // atan(2^-i) in Q.16 degrees
    function automatic ang_t atan_q16(input logic [4:0] i);
        ang_t v;
        begin
            case (i)
                5'd0:    v = 27'sd2949120;
                5'd1:    v = 27'sd1740967;
                5'd2:    v = 27'sd919879;
                5'd3:    v = 27'sd466945;
                5'd4:    v = 27'sd234379;
                5'd5:    v = 27'sd117304;
                5'd6:    v = 27'sd58666;
                5'd7:    v = 27'sd29335;
                5'd8:    v = 27'sd14668;
                5'd9:    v = 27'sd7334;
                5'd10:   v = 27'sd3667;
                5'd11:   v = 27'sd1833;
                5'd12:   v = 27'sd917;
                5'd13:   v = 27'sd458;
                5'd14:   v = 27'sd229;
                5'd15:   v = 27'sd115;
                5'd16:   v = 27'sd57;
                5'd17:   v = 27'sd29;
                5'd18:   v = 27'sd14;
                5'd19:   v = 27'sd7;
                5'd20:   v = 27'sd4;
                5'd21:   v = 27'sd2;
                5'd22:   v = 27'sd1;
                default: v = 27'sd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/fvc_cordic.sv
// Iterative rotation-mode CORDIC: cosine and sine of an angle in degrees.
`default_nettype none
module fvc_cordic #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ANGLE_FRAC_BITS+9:0]    angle,
    output logic                               done,
    output fvc_pkg::trig_t                     cos_out,
    output fvc_pkg::trig_t                     sin_out
);
    import fvc_pkg::*;

    localparam int N  = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;
    localparam int CW = $clog2(N + 1);
    localparam ang_t FULL = 27'sd23592960;
    localparam ang_t D180 = 27'sd11796480;
    localparam ang_t D90  = 27'sd5898240;
    localparam trig_t K_INIT = 33'sd652032874;

    logic          busy_reg, done_reg, flip_reg;
    logic [CW-1:0] it_reg;
    trig_t         x_reg, y_reg, xn, yn, xs, ys, cos_reg, sin_reg;
    ang_t          z_reg, zn, r0, r1, r2;
    logic          fl;

    // range reduction to [-90, 90] with sign flip
    always_comb
    begin
        r0 = ang_t'($signed(angle)) <<< (16 - ANGLE_FRAC_BITS);
        if (r0 > D180)
            r1 = r0 - FULL;
        else if (r0 <= -D180)
            r1 = r0 + FULL;
        else
            r1 = r0;
        fl = 1'b0;
        r2 = r1;
        if (r1 > D90)
        begin
            r2 = r1 - D180;
            fl = 1'b1;
        end
        else if (r1 < -D90)
        begin
            r2 = r1 + D180;
            fl = 1'b1;
        end
    end

    always_comb
    begin
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        if (!z_reg[26])
        begin
            xn = x_reg - ys;
            yn = y_reg + xs;
            zn = z_reg - atan_q16(5'(it_reg));
        end
        else
        begin
            xn = x_reg + ys;
            yn = y_reg - xs;
            zn = z_reg + atan_q16(5'(it_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == CW'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= K_INIT;
            y_reg    <= '0;
            z_reg    <= r2;
            flip_reg <= fl;
        end
        else if (busy_reg)
        begin
            x_reg <= xn;
            y_reg <= yn;
            z_reg <= zn;
            if (it_reg == CW'(N - 1))
            begin
                cos_reg <= flip_reg ? -xn : xn;
                sin_reg <= flip_reg ? -yn : yn;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule
`default_nettype wire

### rtl/fvc_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module fvc_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic        busy_reg, done_reg;
    logic [63:0] s_reg, r_reg, bit_reg, trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (s_reg >= trial)
            begin
                s_reg <= s_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule
`default_nettype wire

### rtl/fvc_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit 15 bits.
`default_nettype none
module fvc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [fvc_pkg::NUM_W-1:0]     num,
    input  wire logic [31:0]                   den,
    output logic                               done,
    output logic [fvc_pkg::QUO_W-1:0]          quo
);
    import fvc_pkg::*;

    logic             busy_reg, done_reg;
    logic [3:0]       it_reg;
    logic [NUM_W-1:0] rem_reg, dsh;
    logic [31:0]      den_reg;
    logic [QUO_W-1:0] q_reg;

    assign dsh = NUM_W'(den_reg) << it_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= 4'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg - 1'b1;
                if (it_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh)
            begin
                rem_reg <= rem_reg - dsh;
                q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
            end
            else
                q_reg <= {q_reg[QUO_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
`default_nettype wire

### rtl/free_look_camera_view_update.sv
// Top level: free-look camera state, sequencer and shared multiplier.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+--------------------------------------
//  s_*      | in        | s_tvalid/tready  | tuser kind, tdata look/zoom/pose
//  m_*      | out       | m_tvalid/tready  | tdata 3x4 view matrix
//  cfg_*    | in        | cfg_we           | cfg_addr index, cfg_wdata value
//
// An accepted pose item runs two CORDIC passes (yaw, then pitch), three square
// roots and nine divisions before m_tvalid; a look or a zoom with nonzero steps
// first updates the angles or the eye position. A zero-length vector skips its
// divisions and is set to zero.
// Reset is asynchronous, active low: yaw -90 deg, pitch 0, eye 0, forward -z.
// s_tready is high only while idle; a finished matrix sits in the output
// register, and a new item may be taken while it waits to be read.
`default_nettype none
module free_look_camera_view_update #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_addr,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // look_dx, look_dy, zoom_steps, new_yaw, new_pitch, new_pos_x/y/z, pad
    input  wire logic [175:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // right_x/y/z, up_x/y/z, back_x/y/z, shift_x/y/z
    output logic [239:0]      m_tdata
);
    import fvc_pkg::*;

    localparam int YAW_W   = ANGLE_FRAC_BITS + 10;
    localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
    localparam int SH      = 16 - ANGLE_FRAC_BITS;
    localparam logic signed [39:0] DEG360  = 40'sd360 <<< ANGLE_FRAC_BITS;
    localparam logic signed [39:0] DEG89   = 40'sd89 <<< ANGLE_FRAC_BITS;
    localparam logic signed [39:0] HALF    = 40'sd1 <<< (SH - 1);
    localparam logic signed [39:0] YAW_MAX = (40'sd1 <<< (YAW_W - 1)) - 40'sd1;
    localparam logic signed [39:0] YAW_MIN = -(40'sd1 <<< (YAW_W - 1));
    localparam logic signed [39:0] PIT_MAX = (40'sd1 <<< (PITCH_W - 1)) - 40'sd1;
    localparam logic signed [39:0] PIT_MIN = -(40'sd1 <<< (PITCH_W - 1));
    localparam logic signed [39:0] YAW_RST = -(40'sd90 <<< ANGLE_FRAC_BITS);

    localparam logic [1:0] NS_FWD   = 2'd0;
    localparam logic [1:0] NS_RIGHT = 2'd1;
    localparam logic [1:0] NS_UP    = 2'd2;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_LOOK  = 12'b0000_0000_0010,
        ST_ZOOM  = 12'b0000_0000_0100,
        ST_TRIGY = 12'b0000_0000_1000,
        ST_TRIGP = 12'b0000_0001_0000,
        ST_RAW   = 12'b0000_0010_0000,
        ST_SQ    = 12'b0000_0100_0000,
        ST_SQRT  = 12'b0000_1000_0000,
        ST_DIV   = 12'b0001_0000_0000,
        ST_CROSS = 12'b0010_0000_0000,
        ST_TRANS = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } state_t;

    function automatic logic signed [39:0] clamp40(input logic signed [39:0] v,
                                                   input logic signed [39:0] lo,
                                                   input logic signed [39:0] hi);
        logic signed [39:0] r;
        begin
            r = (v < lo) ? lo : ((v > hi) ? hi : v);
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        begin
            if (v > 52'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -52'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    // trans step k -> {row, col}
    function automatic logic [3:0] tmap(input logic [3:0] k);
        logic [3:0] r;
        begin
            case (k)
                4'd0:    r = 4'b0000;
                4'd1:    r = 4'b0001;
                4'd2:    r = 4'b0010;
                4'd3:    r = 4'b0100;
                4'd4:    r = 4'b0101;
                4'd5:    r = 4'b0110;
                4'd6:    r = 4'b1000;
                4'd7:    r = 4'b1001;
                4'd8:    r = 4'b1010;
                default: r = 4'b0000;
            endcase
            return r;
        end
    endfunction

    // control and architectural state
    state_t                    state_reg, state_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic [1:0]                idx_reg, idx_next, nsel_reg, nsel_next;
    logic [15:0]               sens_reg, speed_reg;
    logic signed [YAW_W-1:0]   yaw_reg, yaw_next;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    logic signed [31:0]        eye_reg [3], eye_next [3];
    unit_t                     fwd_reg [3], fwd_next [3];
    logic                      ovalid_reg, ovalid_next;

    // payload and work registers
    logic signed [15:0]        dx_reg, dy_reg;
    logic signed [7:0]         steps_reg;
    logic signed [YAW_W-1:0]   ox_reg, ox_next;
    logic signed [24:0]        ss_reg, ss_next;
    trig_t                     cy_reg, sy_reg, cp_reg, sp_reg;
    trig_t                     cy_next, sy_next, cp_next, sp_next;
    trig_t                     vec_reg [3], vec_next [3];
    logic [63:0]               sum_reg, sum_next;
    logic [31:0]               len_reg, len_next;
    logic signed [51:0]        acc_reg, acc_next;
    unit_t                     right_reg [3], right_next [3], up_reg [3], up_next [3];
    logic signed [31:0]        sh_reg [3], sh_next [3];
    logic [239:0]              odata_reg, odata_next;

    // shared multiplier
    logic signed [32:0]        mul_a, mul_b;
    logic signed [65:0]        prod_reg;
    logic signed [51:0]        pv;
    logic signed [39:0]        lp, off, ytmp, ptmp;

    // unit handshakes
    logic                      cor_start, cor_done, sq_start, sq_done, dv_start, dv_done;
    logic [YAW_W-1:0]          cor_angle;
    trig_t                     cor_cos, cor_sin;
    logic [31:0]               sq_root;
    logic [NUM_W-1:0]          dv_num;
    logic [QUO_W-1:0]          dv_quo;
    logic [32:0]               mag;
    unit_t                     nres;

    // index helpers
    logic [1:0]                zi, ze, si, trow, tcol, crow, ccol;
    logic [3:0]                tm_i, tm_c, km1;
    unit_t                     tvec;
    logic                      accept;

    // input fields
    logic signed [15:0]        in_dx, in_dy, in_pitch;
    logic signed [7:0]         in_steps;
    logic signed [17:0]        in_yaw;
    logic signed [31:0]        in_px, in_py, in_pz;

    assign in_dx    = s_tdata[15:0];
    assign in_dy    = s_tdata[31:16];
    assign in_steps = s_tdata[39:32];
    assign in_yaw   = s_tdata[57:40];
    assign in_pitch = s_tdata[73:58];
    assign in_px    = s_tdata[105:74];
    assign in_py    = s_tdata[137:106];
    assign in_pz    = s_tdata[169:138];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    fvc_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    fvc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    fvc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (len_reg),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    assign cor_angle = (state_reg == ST_TRIGY) ? yaw_reg : YAW_W'(pitch_reg);

    // step indexes
    assign zi   = (cnt_reg >= 4'd2 && cnt_reg <= 4'd4) ? 2'(cnt_reg - 4'd2) : 2'd0;
    assign ze   = (cnt_reg >= 4'd3 && cnt_reg <= 4'd5) ? 2'(cnt_reg - 4'd3) : 2'd0;
    assign si   = (cnt_reg < 4'd3) ? cnt_reg[1:0] : 2'd0;
    assign km1  = cnt_reg - 4'd1;
    assign tm_i = tmap(cnt_reg);
    assign tm_c = tmap(km1);
    assign trow = tm_i[3:2];
    assign tcol = tm_i[1:0];
    assign crow = tm_c[3:2];
    assign ccol = tm_c[1:0];
    assign tvec = (trow == 2'd0) ? right_reg[tcol] :
                  (trow == 2'd1) ? up_reg[tcol] : fwd_reg[tcol];

    // operand select for the multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOOK:
            begin
                mul_a = (cnt_reg == 4'd0) ? 33'(dx_reg) : 33'(dy_reg);
                mul_b = $signed({17'd0, sens_reg});
            end
            ST_ZOOM:
            begin
                if (cnt_reg == 4'd0)
                begin
                    mul_a = 33'(steps_reg);
                    mul_b = $signed({17'd0, speed_reg});
                end
                else
                begin
                    mul_a = 33'(ss_reg);
                    mul_b = 33'(fwd_reg[zi]);
                end
            end
            ST_RAW:
            begin
                mul_a = (cnt_reg == 4'd0) ? cy_reg : sy_reg;
                mul_b = cp_reg;
            end
            ST_SQ:
            begin
                mul_a = vec_reg[si];
                mul_b = vec_reg[si];
            end
            ST_CROSS:
            begin
                case (cnt_reg)
                    4'd0:    begin mul_a = 33'(right_reg[1]); mul_b = 33'(fwd_reg[2]); end
                    4'd1:    begin mul_a = 33'(right_reg[2]); mul_b = 33'(fwd_reg[1]); end
                    4'd2:    begin mul_a = 33'(right_reg[2]); mul_b = 33'(fwd_reg[0]); end
                    4'd3:    begin mul_a = 33'(right_reg[0]); mul_b = 33'(fwd_reg[2]); end
                    4'd4:    begin mul_a = 33'(right_reg[0]); mul_b = 33'(fwd_reg[1]); end
                    4'd5:    begin mul_a = 33'(right_reg[1]); mul_b = 33'(fwd_reg[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_TRANS:
            begin
                mul_a = 33'(tvec);
                mul_b = 33'(eye_reg[tcol]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pv  = $signed(prod_reg[51:0]);
    assign lp  = $signed(prod_reg[39:0]);
    assign off = clamp40((lp + HALF) >>> SH, -DEG360, DEG360);
    assign mag = vec_reg[idx_reg][32] ? 33'(-vec_reg[idx_reg]) : 33'(vec_reg[idx_reg]);
    assign dv_num = {mag, 14'd0} + NUM_W'(len_reg >> 1);
    assign nres = vec_reg[idx_reg][32] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        nsel_next   = nsel_reg;
        yaw_next    = yaw_reg;
        pitch_next  = pitch_reg;
        eye_next    = eye_reg;
        fwd_next    = fwd_reg;
        ox_next     = ox_reg;
        ss_next     = ss_reg;
        cy_next     = cy_reg;
        sy_next     = sy_reg;
        cp_next     = cp_reg;
        sp_next     = sp_reg;
        vec_next    = vec_reg;
        sum_next    = sum_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        right_next  = right_reg;
        up_next     = up_reg;
        sh_next     = sh_reg;
        odata_next  = odata_reg;
        ovalid_next = ovalid_reg && !m_tready;
        cor_start   = 1'b0;
        sq_start    = 1'b0;
        dv_start    = 1'b0;
        ytmp        = '0;
        ptmp        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = 4'd0;
                    case (s_tuser)
                        KIND_LOOK: state_next = ST_LOOK;
                        KIND_ZOOM: state_next = (in_steps == 8'sd0) ? ST_TRIGY : ST_ZOOM;
                        KIND_POSE:
                        begin
                            yaw_next    = YAW_W'(clamp40(40'(in_yaw), YAW_MIN, YAW_MAX));
                            pitch_next  = PITCH_W'(clamp40(40'(in_pitch), PIT_MIN, PIT_MAX));
                            eye_next[0] = in_px;
                            eye_next[1] = in_py;
                            eye_next[2] = in_pz;
                            state_next  = ST_TRIGY;
                        end
                        default:   state_next = ST_TRIGY;
                    endcase
                end
            end

            ST_LOOK:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd1)
                    ox_next = YAW_W'(off);
                else if (cnt_reg == 4'd2)
                begin
                    ptmp = clamp40(40'(pitch_reg) + off, -DEG89, DEG89);
                    pitch_next = PITCH_W'(ptmp);
                    ytmp = 40'(yaw_reg) + 40'(ox_reg);
                    if (ytmp < 40'sd0)
                        ytmp = ytmp + DEG360;
                    if (ytmp > DEG360)
                        ytmp = ytmp - DEG360;
                    yaw_next   = YAW_W'(clamp40(ytmp, YAW_MIN, YAW_MAX));
                    cnt_next   = 4'd0;
                    state_next = ST_TRIGY;
                end
            end

            ST_ZOOM:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd1)
                    ss_next = prod_reg[24:0];
                if (cnt_reg >= 4'd3)
                    eye_next[ze] = sat32(52'(eye_reg[ze]) + ((pv + 52'sd32) >>> 6));
                if (cnt_reg == 4'd5)
                begin
                    cnt_next   = 4'd0;
                    state_next = ST_TRIGY;
                end
            end

            ST_TRIGY, ST_TRIGP:
            begin
                if (cnt_reg == 4'd0)
                begin
                    cor_start = 1'b1;
                    cnt_next  = 4'd1;
                end
                else if (cor_done)
                begin
                    cnt_next = 4'd0;
                    if (state_reg == ST_TRIGY)
                    begin
                        cy_next    = cor_cos;
                        sy_next    = cor_sin;
                        state_next = ST_TRIGP;
                    end
                    else
                    begin
                        cp_next    = cor_cos;
                        sp_next    = cor_sin;
                        state_next = ST_RAW;
                    end
                end
            end

            ST_RAW:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd1)
                    vec_next[0] = prod_reg[62:30];
                else if (cnt_reg == 4'd2)
                begin
                    vec_next[2] = prod_reg[62:30];
                    vec_next[1] = sp_reg;
                    nsel_next   = NS_FWD;
                    cnt_next    = 4'd0;
                    state_next  = ST_SQ;
                end
            end

            ST_SQ:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd1)
                    sum_next = prod_reg[63:0];
                else if (cnt_reg >= 4'd2)
                    sum_next = sum_reg + prod_reg[63:0];
                if (cnt_reg == 4'd3)
                begin
                    cnt_next   = 4'd0;
                    state_next = ST_SQRT;
                end
            end

            ST_SQRT:
            begin
                if (cnt_reg == 4'd0)
                begin
                    sq_start = 1'b1;
                    cnt_next = 4'd1;
                end
                else if (sq_done)
                begin
                    len_next   = sq_root;
                    idx_next   = 2'd0;
                    cnt_next   = 4'd0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (cnt_reg == 4'd0 && len_reg != 32'd0)
                begin
                    dv_start = 1'b1;
                    cnt_next = 4'd1;
                end
                else if (cnt_reg == 4'd0 || dv_done)
                begin
                    // zero length: the whole vector becomes zero
                    case (nsel_reg)
                        NS_FWD:   fwd_next[idx_reg]   = (len_reg == 32'd0) ? '0 : nres;
                        NS_RIGHT: right_next[idx_reg] = (len_reg == 32'd0) ? '0 : nres;
                        default:  up_next[idx_reg]    = (len_reg == 32'd0) ? '0 : nres;
                    endcase
                    cnt_next = 4'd0;
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next = 2'd0;
                        case (nsel_reg)
                            NS_FWD:
                            begin
                                // horizontal right candidate: (-fz, 0, fx)
                                vec_next[0] = (len_reg == 32'd0) ? '0 : 33'(-nres);
                                vec_next[1] = '0;
                                vec_next[2] = 33'(fwd_reg[0]);
                                nsel_next   = NS_RIGHT;
                                state_next  = ST_SQ;
                            end
                            NS_RIGHT: state_next = ST_CROSS;
                            default:  state_next = ST_TRANS;
                        endcase
                    end
                end
            end

            ST_CROSS:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg >= 4'd1)
                begin
                    if (!km1[0])
                        acc_next = pv;
                    else
                        vec_next[km1[2:1]] = 33'(acc_reg - pv);
                end
                if (cnt_reg == 4'd6)
                begin
                    cnt_next   = 4'd0;
                    nsel_next  = NS_UP;
                    state_next = ST_SQ;
                end
            end

            ST_TRANS:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg >= 4'd1)
                begin
                    acc_next = ((ccol == 2'd0) ? 52'sd0 : acc_reg) + pv;
                    if (ccol == 2'd2)
                    begin
                        if (crow == 2'd2)
                            sh_next[crow] = sat32((acc_next + 52'sd8192) >>> 14);
                        else
                            sh_next[crow] = sat32(-((acc_next + 52'sd8192) >>> 14));
                    end
                end
                if (cnt_reg == 4'd9)
                begin
                    cnt_next   = 4'd0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    odata_next  = {sh_reg[2], sh_reg[1], sh_reg[0],
                                   16'(-fwd_reg[2]), 16'(-fwd_reg[1]), 16'(-fwd_reg[0]),
                                   up_reg[2], up_reg[1], up_reg[0],
                                   right_reg[2], right_reg[1], right_reg[0]};
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            nsel_reg   <= NS_FWD;
            sens_reg   <= 16'd3277;
            speed_reg  <= 16'd512;
            yaw_reg    <= YAW_W'(YAW_RST);
            pitch_reg  <= '0;
            eye_reg    <= '{default: '0};
            fwd_reg    <= '{16'sd0, 16'sd0, -16'sd16384};
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            nsel_reg   <= nsel_next;
            yaw_reg    <= yaw_next;
            pitch_reg  <= pitch_next;
            eye_reg    <= eye_next;
            fwd_reg    <= fwd_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_SENS: sens_reg  <= cfg_wdata;
                    CFG_ZOOM: speed_reg <= cfg_wdata;
                    default:  sens_reg  <= sens_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        ox_reg    <= ox_next;
        ss_reg    <= ss_next;
        cy_reg    <= cy_next;
        sy_reg    <= sy_next;
        cp_reg    <= cp_next;
        sp_reg    <= sp_next;
        vec_reg   <= vec_next;
        sum_reg   <= sum_next;
        len_reg   <= len_next;
        acc_reg   <= acc_next;
        right_reg <= right_next;
        up_reg    <= up_next;
        sh_reg    <= sh_next;
        odata_reg <= odata_next;
        if (accept)
        begin
            dx_reg    <= in_dx;
            dy_reg    <= in_dy;
            steps_reg <= in_steps;
        end
    end

endmodule
`default_nettype wire
